// ----- hdl/spfc_pkg.sv -----
// Shared types and constants of the switch port flow control block.
package spfc_pkg;

  typedef enum logic [2:0] {
    KIND_ACK_REQ  = 3'd0,
    KIND_FWD_REQ  = 3'd1,
    KIND_ACK_RESP = 3'd2,
    KIND_FWD_RESP = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  localparam logic [1:0] CMD_BEGIN_REQ  = 2'd0;
  localparam logic [1:0] CMD_END_REQ    = 2'd1;
  localparam logic [1:0] CMD_BEGIN_RESP = 2'd2;
  localparam logic [1:0] CMD_END_RESP   = 2'd3;

  localparam logic [1:0] REG_BUS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_REQ_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RESP_LIMIT = 2'd2;

  localparam logic [7:0] BUS_WIDTH_RST  = 8'd32;
  localparam logic [3:0] REQ_LIMIT_RST  = 4'd4;
  localparam logic [3:0] RESP_LIMIT_RST = 4'd4;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic        is_resp;
    logic        is_begin;
    logic        rd;
    logic [7:0]  tag;
    logic [1:0]  origin;
    logic [1:0]  dest;
    logic [15:0] length;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [1:0]  port;
    logic [15:0] beats;
    logic        last;
  } result_t;

endpackage

// ----- hdl/spfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spfc_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/spfc_div.sv -----
// Radix-2 restoring divider giving the rounded-up beat count of a length.
module spfc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] length_i,
  input  logic [8:0]  width_i,
  output logic        done_o,
  output logic [15:0] beats_o
);

  logic        run_q, run_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [8:0]  rem_q, rem_d, div_q, div_d;
  logic [15:0] quo_q, quo_d;
  logic [9:0]  trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q, quo_q[15]};
    ge     = trial >= {1'b0, div_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 5'd16;
      rem_d = '0;
      quo_d = length_i;
      div_d = width_i;
    end else if (run_q) begin
      rem_d = ge ? 9'(trial - {1'b0, div_q}) : trial[8:0];
      quo_d = {quo_q[14:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o  = done_q;
  assign beats_o = quo_q + 16'(rem_q != '0);

endmodule

// ----- hdl/spfc_fifo.sv -----
// Short item queue between the front and the back.
module spfc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  spfc_pkg::item_t     item_i,
  input  logic                pop_i,
  output spfc_pkg::item_t     item_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PW = $clog2(spfc_pkg::FIFO_DEPTH);

  spfc_pkg::item_t                        mem_q [spfc_pkg::FIFO_DEPTH];
  logic [PW-1:0]                          wr_q, rd_q;
  logic [$clog2(spfc_pkg::FIFO_DEPTH+1)-1:0] cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == ($bits(cnt_q))'(spfc_pkg::FIFO_DEPTH);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(spfc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(spfc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/spfc_front.sv -----
// Front: decode the command, drop events on absent ports, queue the rest.
module spfc_front #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic            start_i,
  input  logic            full_i,
  input  logic [1:0]      cmd_i,
  input  logic [7:0]      tag_i,
  input  logic            is_read_i,
  input  logic [1:0]      origin_i,
  input  logic [1:0]      dest_i,
  input  logic [15:0]     length_i,
  output logic            push_o,
  output spfc_pkg::item_t item_o
);

  logic drop;

  assign drop = (int'(origin_i) >= NUM_PORTS) || (int'(dest_i) >= NUM_PORTS);

  always_comb begin
    item_o.is_resp  = (cmd_i == spfc_pkg::CMD_BEGIN_RESP) ||
                      (cmd_i == spfc_pkg::CMD_END_RESP);
    item_o.is_begin = (cmd_i == spfc_pkg::CMD_BEGIN_REQ) ||
                      (cmd_i == spfc_pkg::CMD_BEGIN_RESP);
    item_o.rd       = is_read_i;
    item_o.tag      = tag_i;
    item_o.origin   = origin_i;
    item_o.dest     = dest_i;
    item_o.length   = length_i;
  end

  assign push_o = start_i && !full_i && !drop;

endmodule

// ----- hdl/spfc_back.sv -----
// Back: per-channel busy flags, queues and pending queues; emits results.
module spfc_back #(
  parameter int unsigned NUM_PORTS     = 4,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PENDING_DEPTH = 8,
  parameter int unsigned TAG_BITS      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spfc_pkg::item_t   item_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [7:0]        bus_width_i,
  input  logic [3:0]        req_limit_i,
  input  logic [3:0]        resp_limit_i,
  output logic              res_valid_o,
  output spfc_pkg::result_t res_o
);

  localparam int unsigned NCHAN = NUM_PORTS * 4;
  localparam int unsigned CH_W  = $clog2(NCHAN);
  localparam int unsigned QH_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PH_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned EW    = TAG_BITS + 20;
  localparam int unsigned QA_W  = $clog2(NCHAN * QUEUE_DEPTH);
  localparam int unsigned PA_W  = $clog2(NCHAN * PENDING_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_PROM   = 3'd2;
  localparam logic [2:0] S_QISSUE = 3'd3;
  localparam logic [2:0] S_QRD    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FWD1   = 3'd6;

  logic [2:0]          state_q, state_d;
  spfc_pkg::item_t     item_q, item_d;
  logic [NCHAN-1:0]    busy_q, busy_d;
  logic [QH_W-1:0]     qhead_q [NCHAN];
  logic [QH_W-1:0]     qhead_d [NCHAN];
  logic [QC_W-1:0]     qcnt_q  [NCHAN];
  logic [QC_W-1:0]     qcnt_d  [NCHAN];
  logic [PH_W-1:0]     phead_q [NCHAN];
  logic [PH_W-1:0]     phead_d [NCHAN];
  logic [PC_W-1:0]     pcnt_q  [NCHAN];
  logic [PC_W-1:0]     pcnt_d  [NCHAN];
  logic [TAG_BITS-1:0] fwd_tag_q, fwd_tag_d;
  logic [1:0]          fwd_port_q, fwd_port_d;
  logic                res_valid_q, res_valid_d;
  spfc_pkg::result_t   res_q, res_d;

  logic [CH_W-1:0]     ch;
  logic [QH_W-1:0]     qhead;
  logic [QC_W-1:0]     qcnt;
  logic [PH_W-1:0]     phead;
  logic [PC_W-1:0]     pcnt;
  logic [6:0]          limit;
  logic                room, force1;
  logic [QC_W:0]       qsum;
  logic [PC_W:0]       psum;
  logic [QH_W-1:0]     qpos;
  logic [PH_W-1:0]     ppos;
  logic [EW-1:0]       cur_ent, q_wdata, q_rdata, p_rdata;
  logic                q_we, p_we;
  logic [QA_W-1:0]     q_waddr, q_raddr;
  logic [PA_W-1:0]     p_waddr, p_raddr;
  logic                div_start, div_done;
  logic [15:0]         div_len, div_beats;
  spfc_pkg::kind_e     ack_kind, fwd_kind;

  assign ch     = CH_W'({(item_q.is_resp ? item_q.origin : item_q.dest),
                         item_q.is_resp, item_q.rd});
  assign qhead  = qhead_q[ch];
  assign qcnt   = qcnt_q[ch];
  assign phead  = phead_q[ch];
  assign pcnt   = pcnt_q[ch];
  assign force1 = item_q.is_resp != item_q.rd;
  assign ack_kind = item_q.is_resp ? spfc_pkg::KIND_ACK_RESP : spfc_pkg::KIND_ACK_REQ;
  assign fwd_kind = item_q.is_resp ? spfc_pkg::KIND_FWD_RESP : spfc_pkg::KIND_FWD_REQ;

  always_comb begin
    limit = 7'(item_q.is_resp ? resp_limit_i : req_limit_i);
    if (limit > 7'(QUEUE_DEPTH)) begin
      limit = 7'(QUEUE_DEPTH);
    end
    room = 7'(qcnt) < limit;
    qsum = (QC_W + 1)'(qhead) + (QC_W + 1)'(qcnt);
    if (qsum >= (QC_W + 1)'(QUEUE_DEPTH)) begin
      qsum = qsum - (QC_W + 1)'(QUEUE_DEPTH);
    end
    psum = (PC_W + 1)'(phead) + (PC_W + 1)'(pcnt);
    if (psum >= (PC_W + 1)'(PENDING_DEPTH)) begin
      psum = psum - (PC_W + 1)'(PENDING_DEPTH);
    end
    qpos = QH_W'(qsum);
    ppos = PH_W'(psum);
  end

  assign cur_ent = {TAG_BITS'(item_q.tag), item_q.origin, item_q.dest, item_q.length};
  assign q_waddr = QA_W'(ch) * QA_W'(QUEUE_DEPTH) + QA_W'(qpos);
  assign q_raddr = QA_W'(ch) * QA_W'(QUEUE_DEPTH) + QA_W'(qhead);
  assign p_waddr = PA_W'(ch) * PA_W'(PENDING_DEPTH) + PA_W'(ppos);
  assign p_raddr = PA_W'(ch) * PA_W'(PENDING_DEPTH) + PA_W'(phead);
  assign q_wdata = (state_q == S_PROM) ? p_rdata : cur_ent;
  assign div_len = (state_q == S_QRD) ? q_rdata[15:0] : item_q.length;
  assign pop_o   = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    busy_d      = busy_q;
    qhead_d     = qhead_q;
    qcnt_d      = qcnt_q;
    phead_d     = phead_q;
    pcnt_d      = pcnt_q;
    fwd_tag_d   = fwd_tag_q;
    fwd_port_d  = fwd_port_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_we        = 1'b0;
    p_we        = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          item_d  = item_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (item_q.is_begin) begin
          if (!busy_q[ch]) begin
            res_valid_d = 1'b1;
            res_d = '{ack_kind, item_q.tag,
                      item_q.is_resp ? item_q.dest : item_q.origin, 16'd0, 1'b0};
            busy_d[ch] = 1'b1;
            fwd_tag_d  = TAG_BITS'(item_q.tag);
            fwd_port_d = item_q.is_resp ? item_q.origin : item_q.dest;
            div_start  = !force1;
            state_d    = force1 ? S_FWD1 : S_DIV;
          end else if (room) begin
            res_valid_d = 1'b1;
            res_d = '{ack_kind, item_q.tag,
                      item_q.is_resp ? item_q.dest : item_q.origin, 16'd0, 1'b1};
            q_we       = 1'b1;
            qcnt_d[ch] = qcnt + 1'b1;
            state_d    = S_IDLE;
          end else if (pcnt < PC_W'(PENDING_DEPTH)) begin
            p_we       = 1'b1;
            pcnt_d[ch] = pcnt + 1'b1;
            state_d    = S_IDLE;
          end else begin
            res_valid_d = 1'b1;
            res_d = '{spfc_pkg::KIND_OVERFLOW, item_q.tag,
                      item_q.is_resp ? item_q.dest : item_q.origin, 16'd0, 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          if ((pcnt != '0) && room) begin
            state_d = S_PROM;
          end else if (qcnt != '0) begin
            state_d = S_QRD;
          end else begin
            busy_d[ch] = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      S_PROM: begin
        res_valid_d = 1'b1;
        res_d = '{ack_kind, 8'(p_rdata[EW-1:20]),
                  item_q.is_resp ? p_rdata[17:16] : p_rdata[19:18], 16'd0, 1'b0};
        q_we        = 1'b1;
        qcnt_d[ch]  = qcnt + 1'b1;
        pcnt_d[ch]  = pcnt - 1'b1;
        phead_d[ch] = (phead == PH_W'(PENDING_DEPTH - 1)) ? '0 : phead + 1'b1;
        state_d     = S_QISSUE;
      end
      S_QISSUE: begin
        state_d = S_QRD;
      end
      S_QRD: begin
        fwd_tag_d   = q_rdata[EW-1:20];
        fwd_port_d  = item_q.is_resp ? q_rdata[19:18] : q_rdata[17:16];
        qcnt_d[ch]  = qcnt - 1'b1;
        qhead_d[ch] = (qhead == QH_W'(QUEUE_DEPTH - 1)) ? '0 : qhead + 1'b1;
        div_start   = !force1;
        state_d     = force1 ? S_FWD1 : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_valid_d = 1'b1;
          res_d   = '{fwd_kind, 8'(fwd_tag_q), fwd_port_q, div_beats, 1'b1};
          state_d = S_IDLE;
        end
      end
      S_FWD1: begin
        res_valid_d = 1'b1;
        res_d   = '{fwd_kind, 8'(fwd_tag_q), fwd_port_q, 16'd1, 1'b1};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NCHAN; i++) begin
        qhead_q[i] <= '0;
        qcnt_q[i]  <= '0;
        phead_q[i] <= '0;
        pcnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      qhead_q     <= qhead_d;
      qcnt_q      <= qcnt_d;
      phead_q     <= phead_d;
      pcnt_q      <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    fwd_tag_q  <= fwd_tag_d;
    fwd_port_q <= fwd_port_d;
    res_q      <= res_d;
  end

  spfc_ram #(.WIDTH(EW), .DEPTH(NCHAN * QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  spfc_ram #(.WIDTH(EW), .DEPTH(NCHAN * PENDING_DEPTH)) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (cur_ent),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  spfc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .length_i (div_len),
    .width_i  ({bus_width_i == 8'd0, bus_width_i}),
    .done_o   (div_done),
    .beats_o  (div_beats)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/switch_port_flow_control.sv -----
// Top level of the switch port flow control block.
// Events enter on start while busy is low; up to two events wait in an input queue and busy
// rises when it is full. Each event gives zero, one or two results, one at a time, each shown
// for a single cycle with result_valid_o and last_o on the final one; results cannot be held
// off. A one-beat item needs no division, and other forwards wait for a beat count: the count
// comes from a one-bit-per-cycle divider over the 16-bit length, and queued entries are read
// from the queue RAM, whose read data is registered.
module switch_port_flow_control #(
  parameter int unsigned NUM_PORTS     = 4,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PENDING_DEPTH = 8,
  parameter int unsigned TAG_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  transaction_tag_i,
  input  logic        is_read_i,
  input  logic [1:0]  origin_port_i,
  input  logic [1:0]  dest_port_i,
  input  logic [15:0] data_length_i,
  output logic        result_valid_o,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  out_tag_o,
  output logic [1:0]  out_port_o,
  output logic [15:0] beats_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        bus_width_q;
  logic [3:0]        req_limit_q, resp_limit_q;
  logic              push, pop, empty, full, cfg_wr;
  spfc_pkg::item_t   front_item, fifo_item;
  spfc_pkg::result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_width_q  <= spfc_pkg::BUS_WIDTH_RST;
      req_limit_q  <= spfc_pkg::REQ_LIMIT_RST;
      resp_limit_q <= spfc_pkg::RESP_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        spfc_pkg::REG_BUS_WIDTH:  bus_width_q  <= pwdata[7:0];
        spfc_pkg::REG_REQ_LIMIT:  req_limit_q  <= pwdata[3:0];
        spfc_pkg::REG_RESP_LIMIT: resp_limit_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spfc_pkg::REG_BUS_WIDTH:  prdata = {24'd0, bus_width_q};
      spfc_pkg::REG_REQ_LIMIT:  prdata = {28'd0, req_limit_q};
      spfc_pkg::REG_RESP_LIMIT: prdata = {28'd0, resp_limit_q};
      default:                  prdata = '0;
    endcase
  end

  spfc_front #(.NUM_PORTS(NUM_PORTS)) u_front (
    .start_i   (start),
    .full_i    (full),
    .cmd_i     (cmd_i),
    .tag_i     (transaction_tag_i),
    .is_read_i (is_read_i),
    .origin_i  (origin_port_i),
    .dest_i    (dest_port_i),
    .length_i  (data_length_i),
    .push_o    (push),
    .item_o    (front_item)
  );

  spfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (fifo_item),
    .empty_o (empty),
    .full_o  (full)
  );

  spfc_back #(
    .NUM_PORTS     (NUM_PORTS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH),
    .TAG_BITS      (TAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (fifo_item),
    .empty_i      (empty),
    .pop_o        (pop),
    .bus_width_i  (bus_width_q),
    .req_limit_i  (req_limit_q),
    .resp_limit_i (resp_limit_q),
    .res_valid_o  (result_valid_o),
    .res_o        (res)
  );

  assign busy         = full;
  assign event_kind_o = res.kind;
  assign out_tag_o    = res.tag;
  assign out_port_o   = res.port;
  assign beats_o      = res.beats;
  assign last_o       = res.last;

endmodule

// ----- hdl/spfc_checker.sv -----
// Port-level checks of the switch port flow control block, bound to the top level.
module spfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [2:0]  event_kind_o,
  input logic [15:0] beats_o,
  input logic        last_o,
  input logic        pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (event_kind_o == spfc_pkg::KIND_OVERFLOW) |-> last_o)
    else $error("overflow result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |->
      (event_kind_o == spfc_pkg::KIND_ACK_REQ) || (event_kind_o == spfc_pkg::KIND_ACK_RESP))
    else $error("non-final result is not an ack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((event_kind_o == spfc_pkg::KIND_ACK_REQ) ||
      (event_kind_o == spfc_pkg::KIND_ACK_RESP) ||
      (event_kind_o == spfc_pkg::KIND_OVERFLOW)) |-> (beats_o == 16'd0))
    else $error("beats set on a non-forward result");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind switch_port_flow_control spfc_checker u_spfc_checker (.*);

// ----- bench/spfc_checker.sv -----
// Checker for the switch port flow control block: predicts the results of each item and compares.
module spfc_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  transaction_tag_i,
  input  logic        is_read_i,
  input  logic [1:0]  origin_port_i,
  input  logic [1:0]  dest_port_i,
  input  logic [15:0] data_length_i,
  input  logic        result_valid_o,
  input  logic [2:0]  event_kind_o,
  input  logic [7:0]  out_tag_o,
  input  logic [1:0]  out_port_o,
  input  logic [15:0] beats_o,
  input  logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam int NCH     = 16;
  localparam int QD      = 8;
  localparam int PD      = 8;
  localparam int EXP_BUF = 256;

  typedef struct packed {
    logic [7:0]  tag;
    logic [1:0]  origin;
    logic [1:0]  dest;
    logic [15:0] length;
  } txn_t;

  logic [7:0] bus_width;
  logic [3:0] req_limit;
  logic [3:0] resp_limit;

  logic       chan_busy [NCH];
  txn_t       q_mem     [NCH][QD];
  int         q_head    [NCH];
  int         q_cnt     [NCH];
  txn_t       p_mem     [NCH][PD];
  int         p_head    [NCH];
  int         p_cnt     [NCH];

  spfc_pkg::result_t exp_buf [EXP_BUF];
  int                exp_wr;
  int                exp_rd;
  int                fails;

  assign fail_count_o  = fails;
  assign outstanding_o = exp_wr - exp_rd;

  function automatic logic [15:0] beats_for(logic [15:0] len, logic resp, logic rd);
    int w;
    w = (bus_width == 8'd0) ? 256 : int'(bus_width);
    if (resp != rd) return 16'd1;
    return 16'((int'(len) + w - 1) / w);
  endfunction

  task automatic add_result(spfc_pkg::kind_e k, logic [7:0] tag, logic [1:0] port,
                            logic [15:0] b);
    spfc_pkg::result_t r;
    r.kind  = k;
    r.tag   = tag;
    r.port  = port;
    r.beats = b;
    r.last  = 1'b0;
    exp_buf[exp_wr % EXP_BUF] = r;
    exp_wr++;
  endtask

  task automatic predict_event(logic [1:0] cmd, txn_t cur, logic rd);
    logic            resp, beg;
    spfc_pkg::kind_e ack_k, fwd_k;
    int              lim, ch, pos, n0;
    txn_t            e;
    resp  = (cmd == spfc_pkg::CMD_BEGIN_RESP) || (cmd == spfc_pkg::CMD_END_RESP);
    beg   = (cmd == spfc_pkg::CMD_BEGIN_REQ) || (cmd == spfc_pkg::CMD_BEGIN_RESP);
    ack_k = resp ? spfc_pkg::KIND_ACK_RESP : spfc_pkg::KIND_ACK_REQ;
    fwd_k = resp ? spfc_pkg::KIND_FWD_RESP : spfc_pkg::KIND_FWD_REQ;
    lim   = resp ? int'(resp_limit) : int'(req_limit);
    if (lim > QD) lim = QD;
    ch    = ((int'(resp ? cur.origin : cur.dest) * 2 + int'(resp)) * 2 + int'(rd)) % NCH;
    n0    = exp_wr;
    if (beg) begin
      if (!chan_busy[ch] || q_cnt[ch] < lim)
        add_result(ack_k, cur.tag, resp ? cur.dest : cur.origin, 16'd0);
      if (!chan_busy[ch]) begin
        chan_busy[ch] = 1'b1;
        add_result(fwd_k, cur.tag, resp ? cur.origin : cur.dest,
                   beats_for(cur.length, resp, rd));
      end else if (q_cnt[ch] < lim) begin
        q_mem[ch][(q_head[ch] + q_cnt[ch]) % QD] = cur;
        q_cnt[ch]++;
      end else if (p_cnt[ch] < PD) begin
        p_mem[ch][(p_head[ch] + p_cnt[ch]) % PD] = cur;
        p_cnt[ch]++;
      end else begin
        add_result(spfc_pkg::KIND_OVERFLOW, cur.tag, resp ? cur.dest : cur.origin, 16'd0);
      end
    end else begin
      if (p_cnt[ch] > 0 && q_cnt[ch] < lim) begin
        e = p_mem[ch][p_head[ch]];
        add_result(ack_k, e.tag, resp ? e.dest : e.origin, 16'd0);
        p_head[ch] = (p_head[ch] + 1) % PD;
        p_cnt[ch]--;
        pos = (q_head[ch] + q_cnt[ch]) % QD;
        q_mem[ch][pos] = e;
        q_cnt[ch]++;
      end
      if (q_cnt[ch] > 0) begin
        e = q_mem[ch][q_head[ch]];
        add_result(fwd_k, e.tag, resp ? e.origin : e.dest, beats_for(e.length, resp, rd));
        q_head[ch] = (q_head[ch] + 1) % QD;
        q_cnt[ch]--;
      end else begin
        chan_busy[ch] = 1'b0;
      end
    end
    if (exp_wr > n0) exp_buf[(exp_wr - 1) % EXP_BUF].last = 1'b1;
  endtask

  task automatic report(string what, spfc_pkg::result_t exp);
    fails++;
    if (fails <= 10)
      $display({"mismatch %0s: exp kind %0d tag %0d port %0d beats %0d last %0d, ",
                "got kind %0d tag %0d port %0d beats %0d last %0d"},
               what, exp.kind, exp.tag, exp.port, exp.beats, exp.last,
               event_kind_o, out_tag_o, out_port_o, beats_o, last_o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    txn_t              cur;
    spfc_pkg::result_t exp;
    if (!rst_ni) begin
      bus_width  = spfc_pkg::BUS_WIDTH_RST;
      req_limit  = spfc_pkg::REQ_LIMIT_RST;
      resp_limit = spfc_pkg::RESP_LIMIT_RST;
      for (int i = 0; i < NCH; i++) begin
        chan_busy[i] = 1'b0;
        q_head[i]    = 0;
        q_cnt[i]     = 0;
        p_head[i]    = 0;
        p_cnt[i]     = 0;
      end
      exp_wr = 0;
      exp_rd = 0;
      fails  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          spfc_pkg::REG_BUS_WIDTH:  bus_width  = pwdata[7:0];
          spfc_pkg::REG_REQ_LIMIT:  req_limit  = pwdata[3:0];
          spfc_pkg::REG_RESP_LIMIT: resp_limit = pwdata[3:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        if (exp_wr == exp_rd) begin
          exp = '0;
          report("unexpected result", exp);
        end else begin
          exp = exp_buf[exp_rd % EXP_BUF];
          exp_rd++;
          if (event_kind_o !== exp.kind || out_tag_o !== exp.tag || out_port_o !== exp.port
              || beats_o !== exp.beats || last_o !== exp.last)
            report("field", exp);
        end
      end
      if (start && !busy) begin
        cur.tag    = transaction_tag_i;
        cur.origin = origin_port_i;
        cur.dest   = dest_port_i;
        cur.length = data_length_i;
        predict_event(cmd_i, cur, is_read_i);
      end
    end
  end

endmodule

// ----- bench/tb_switch_port_flow_control.sv -----
// Testbench top of the switch port flow control block: stimulus, register writes and verdict.
module tb_switch_port_flow_control;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [7:0]  transaction_tag_i;
  logic        is_read_i;
  logic [1:0]  origin_port_i;
  logic [1:0]  dest_port_i;
  logic [15:0] data_length_i;
  logic        result_valid_o;
  logic [2:0]  event_kind_o;
  logic [7:0]  out_tag_o;
  logic [1:0]  out_port_o;
  logic [15:0] beats_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          idle_pct;

  switch_port_flow_control dut (.*);

  spfc_scoreboard chk (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .transaction_tag_i, .is_read_i,
    .origin_port_i, .dest_port_i, .data_length_i, .result_valid_o, .event_kind_o,
    .out_tag_o, .out_port_o, .beats_o, .last_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .pready, .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #24000000;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] tag, logic rd, logic [1:0] org,
                           logic [1:0] dst, logic [15:0] len);
    cmd_i             <= cmd;
    transaction_tag_i <= tag;
    is_read_i         <= rd;
    origin_port_i     <= org;
    dest_port_i       <= dst;
    data_length_i     <= len;
    start             <= 1'b1;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] bw, logic [3:0] rq, logic [3:0] rs);
    drain();
    reg_write(spfc_pkg::REG_BUS_WIDTH, {24'd0, bw});
    reg_write(spfc_pkg::REG_REQ_LIMIT, {28'd0, rq});
    reg_write(spfc_pkg::REG_RESP_LIMIT, {28'd0, rs});
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_part(int count);
    int          sent, k, nend;
    logic        resp, rd;
    logic [1:0]  key, other;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 70) begin
        resp  = 1'($urandom_range(1));
        rd    = 1'($urandom_range(1));
        key   = 2'($urandom_range(3));
        k     = int'($urandom_range(1, 14));
        nend  = int'($urandom_range(k / 2, k + 2));
        for (int i = 0; i < k; i++) begin
          other = 2'($urandom_range(3));
          if (resp)
            send_item(spfc_pkg::CMD_BEGIN_RESP, 8'($urandom), rd, key, other, pick_len());
          else
            send_item(spfc_pkg::CMD_BEGIN_REQ, 8'($urandom), rd, other, key, pick_len());
        end
        for (int i = 0; i < nend; i++) begin
          other = 2'($urandom_range(3));
          if (resp)
            send_item(spfc_pkg::CMD_END_RESP, 8'($urandom), rd, key, other, pick_len());
          else
            send_item(spfc_pkg::CMD_END_REQ, 8'($urandom), rd, other, key, pick_len());
        end
        sent += k + nend;
      end else begin
        send_item(2'($urandom), 8'($urandom), 1'($urandom), 2'($urandom), 2'($urandom),
                  pick_len());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    start             = 1'b0;
    cmd_i             = spfc_pkg::CMD_BEGIN_REQ;
    transaction_tag_i = '0;
    is_read_i         = 1'b0;
    origin_port_i     = '0;
    dest_port_i       = '0;
    data_length_i     = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    idle_pct          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(spfc_pkg::CMD_END_REQ, 8'd1, 1'b0, 2'd0, 2'd0, 16'd10);
    send_item(spfc_pkg::CMD_END_RESP, 8'd2, 1'b1, 2'd3, 2'd3, 16'd10);
    send_item(spfc_pkg::CMD_BEGIN_REQ, 8'd0, 1'b0, 2'd0, 2'd3, 16'hFFFF);
    send_item(spfc_pkg::CMD_BEGIN_REQ, 8'd255, 1'b0, 2'd3, 2'd3, 16'd0);
    send_item(spfc_pkg::CMD_BEGIN_REQ, 8'd7, 1'b1, 2'd1, 2'd3, 16'd100);
    send_item(spfc_pkg::CMD_BEGIN_RESP, 8'd9, 1'b0, 2'd2, 2'd1, 16'd64);
    send_item(spfc_pkg::CMD_BEGIN_RESP, 8'd10, 1'b1, 2'd2, 2'd0, 16'd65);
    send_item(spfc_pkg::CMD_BEGIN_RESP, 8'd11, 1'b1, 2'd2, 2'd3, 16'hFFFF);
    send_item(spfc_pkg::CMD_END_REQ, 8'd0, 1'b0, 2'd0, 2'd3, 16'd0);
    send_item(spfc_pkg::CMD_END_REQ, 8'd0, 1'b0, 2'd0, 2'd3, 16'd0);
    send_item(spfc_pkg::CMD_END_RESP, 8'd0, 1'b1, 2'd2, 2'd0, 16'd0);
    send_item(spfc_pkg::CMD_END_RESP, 8'd0, 1'b1, 2'd2, 2'd0, 16'd0);
    send_item(spfc_pkg::CMD_END_RESP, 8'd0, 1'b0, 2'd2, 2'd0, 16'd0);
    send_item(spfc_pkg::CMD_END_REQ, 8'd0, 1'b1, 2'd1, 2'd3, 16'd0);

    set_regs(8'd1, 4'd1, 4'd15);
    for (int i = 0; i < 11; i++)
      send_item(spfc_pkg::CMD_BEGIN_REQ, 8'(100 + i), 1'b0, 2'(i), 2'd2, 16'(i * 3));
    for (int i = 0; i < 11; i++)
      send_item(spfc_pkg::CMD_END_REQ, 8'hAA, 1'b0, 2'd0, 2'd2, 16'd0);

    idle_pct = 28;
    random_part(300);
    set_regs(8'd255, 4'd8, 4'd1);
    idle_pct = 85;
    random_part(300);
    set_regs(8'd0, 4'd0, 4'd8);
    idle_pct = 0;
    random_part(150);
    set_regs(8'd7, 4'd2, 4'd3);
    random_part(150);

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
